/* src/packed_pixel_framebuffer_defines.svh */
// ---------------------------------------------------------------------------
// packed_pixel_framebuffer_defines
// Assertion macros shared by the frame buffer RTL.
// ---------------------------------------------------------------------------
`ifndef PACKED_PIXEL_FRAMEBUFFER_DEFINES_SVH
`define PACKED_PIXEL_FRAMEBUFFER_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define PPFB_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ppfb assertion failed");

// next-cycle implication
`define PPFB_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ppfb assertion failed");

`else

`define PPFB_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define PPFB_ASSERT_NXT(lbl, clk, rst_n, pre, post)

`endif

`endif

/* src/ppfb_pkg.sv */
// ---------------------------------------------------------------------------
// ppfb_pkg
// Types and constants of the packed pixel frame buffer.
// ---------------------------------------------------------------------------
package ppfb_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(MEM_DEPTH);
	localparam int QUEUE_DEPTH = 2;

	// action codes of an input transaction
	localparam logic [1:0] ACT_READ  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
	localparam logic [1:0] REG_PIXEL_SIZE   = 2'd2;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic [7:0]         color;
	} item_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] pixel_value;
	} result_t;

	typedef struct packed {
		logic [8:0] frame_width;
		logic [8:0] frame_height;
		logic [1:0] pixel_size_log2;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_READ,
		OP_WRITE,
		OP_CLEAR,
		OP_REJECT
	} op_t;

	// classified command passed from front to back
	typedef struct packed {
		op_t               op;
		logic [ADDR_W-1:0] addr;
		logic [2:0]        shift;
		logic [7:0]        mask;
		logic [7:0]        data;   // masked color (write) or fill byte (clear)
		logic [ADDR_W:0]   count;  // bytes to clear
	} cmd_t;

	typedef enum logic [1:0] {
		BS_IDLE,
		BS_RMW,
		BS_CLEAR
	} back_state_t;

endpackage

/* src/ppfb_front.sv */
// ---------------------------------------------------------------------------
// ppfb_front
// Takes a transaction, checks its coordinates and works out the byte address,
// pixel slot and fill pattern.
// ---------------------------------------------------------------------------
module ppfb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  ppfb_pkg::item_t  item,
	input  ppfb_pkg::cfg_t   cfg,
	input  logic             full,
	output logic             push,
	output ppfb_pkg::cmd_t   cmd,
	output logic             pending
);

	logic            valid_s1;
	ppfb_pkg::item_t item_s1;

	logic [8:0]  eff_w, eff_h, row_bytes, mul_b;
	logic [9:0]  w_round;
	logic [2:0]  pm;
	logic [1:0]  per_log2;
	logic [3:0]  bits;
	logic [7:0]  mask, c, fill, col;
	logic [17:0] prod, addr_sum;
	logic        in_frame, is_clear;

	assign push    = valid_s1 && !full;
	assign pending = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item;
		end
	end

	always_comb begin
		eff_w = (cfg.frame_width > 9'(ppfb_pkg::MAX_WIDTH)) ?
			9'(ppfb_pkg::MAX_WIDTH) : cfg.frame_width;
		eff_h = (cfg.frame_height > 9'(ppfb_pkg::MAX_HEIGHT)) ?
			9'(ppfb_pkg::MAX_HEIGHT) : cfg.frame_height;
		per_log2  = 2'd3 - cfg.pixel_size_log2;
		pm        = 3'b111 >> cfg.pixel_size_log2;
		bits      = 4'd1 << cfg.pixel_size_log2;
		mask      = 8'hFF >> (4'd8 - bits);
		w_round   = {1'b0, eff_w} + {7'd0, pm};
		row_bytes = 9'(w_round >> per_log2);

		is_clear = (item_s1.action == ppfb_pkg::ACT_CLEAR);
		in_frame = !item_s1.x[15] && !item_s1.y[15] &&
			($unsigned(item_s1.x) < {7'd0, eff_w}) &&
			($unsigned(item_s1.y) < {7'd0, eff_h});

		mul_b    = is_clear ? eff_h : {1'b0, item_s1.y[7:0]};
		prod     = {9'd0, row_bytes} * {9'd0, mul_b};
		col      = item_s1.x[7:0] >> per_log2;
		addr_sum = prod + {10'd0, col};

		c = item_s1.color & mask;
		case (cfg.pixel_size_log2)
			2'd0:    fill = {8{c[0]}};
			2'd1:    fill = {4{c[1:0]}};
			2'd2:    fill = {2{c[3:0]}};
			default: fill = c;
		endcase

		cmd.addr  = (|addr_sum[17:16]) ? {ppfb_pkg::ADDR_W{1'b1}} : addr_sum[15:0];
		// distance of the slot from the low end of the byte, in bits
		cmd.shift = 3'((~item_s1.x[2:0] & pm) << cfg.pixel_size_log2);
		cmd.mask  = mask;
		cmd.count = prod[ppfb_pkg::ADDR_W:0];
		cmd.data  = is_clear ? fill : c;

		case (item_s1.action)
			ppfb_pkg::ACT_CLEAR: cmd.op = ppfb_pkg::OP_CLEAR;
			ppfb_pkg::ACT_READ:  cmd.op = in_frame ? ppfb_pkg::OP_READ : ppfb_pkg::OP_REJECT;
			ppfb_pkg::ACT_WRITE: cmd.op = in_frame ? ppfb_pkg::OP_WRITE : ppfb_pkg::OP_REJECT;
			default:             cmd.op = ppfb_pkg::OP_REJECT;
		endcase
	end

endmodule

/* src/ppfb_queue.sv */
// ---------------------------------------------------------------------------
// ppfb_queue
// Short command queue between the front and back parts.
// ---------------------------------------------------------------------------
`include "packed_pixel_framebuffer_defines.svh"

module ppfb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ppfb_pkg::cmd_t wr_cmd,
	input  logic           pop,
	output ppfb_pkg::cmd_t head,
	output logic           empty,
	output logic           full
);

	localparam int PTR_W = $clog2(ppfb_pkg::QUEUE_DEPTH);

	ppfb_pkg::cmd_t     entry_q [ppfb_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [PTR_W:0]     count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (PTR_W+1)'(ppfb_pkg::QUEUE_DEPTH));
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

	`PPFB_ASSERT_IMP(a_no_overflow, clk, arst_n, push && !pop, !full)
	`PPFB_ASSERT_IMP(a_no_underflow, clk, arst_n, pop, !empty)
	`PPFB_ASSERT_NXT(a_push_lands, clk, arst_n, push && !pop, !empty)

endmodule

/* src/ppfb_back.sv */
// ---------------------------------------------------------------------------
// ppfb_back
// Carries out commands against the byte memory: pixel read, pixel
// read-modify-write and the clear walk. Drives the result strobe.
// ---------------------------------------------------------------------------
`include "packed_pixel_framebuffer_defines.svh"

module ppfb_back (
	input  logic              clk,
	input  logic              arst_n,
	input  ppfb_pkg::cmd_t    head,
	input  logic              empty,
	output logic              pop,
	output logic              active,
	output logic              done,
	output ppfb_pkg::result_t result
);

	ppfb_pkg::back_state_t state_q, state_d;
	ppfb_pkg::cmd_t        cur_q;
	logic [7:0]            mem_q [ppfb_pkg::MEM_DEPTH];
	logic [7:0]            rd_q;
	logic [ppfb_pkg::ADDR_W-1:0] clr_addr_q, wr_addr;
	logic [7:0]            wr_data, merged, extracted;
	logic                  rd_en, wr_en, last, head_pixel, head_quick;
	logic                  done_d, done_q;
	ppfb_pkg::result_t     result_d, result_q;

	assign head_pixel = (head.op == ppfb_pkg::OP_READ) || (head.op == ppfb_pkg::OP_WRITE);
	// commands that finish without touching memory
	assign head_quick = (head.op == ppfb_pkg::OP_REJECT) ||
		((head.op == ppfb_pkg::OP_CLEAR) && (head.count == '0));
	assign last = ({1'b0, clr_addr_q} + 1'b1) == cur_q.count;

	assign extracted = (rd_q >> cur_q.shift) & cur_q.mask;
	assign merged    = (rd_q & ~(cur_q.mask << cur_q.shift)) | (cur_q.data << cur_q.shift);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ppfb_pkg::BS_IDLE: begin
				if (!empty && head_pixel) begin
					state_d = ppfb_pkg::BS_RMW;
				end else if (!empty && !head_quick) begin
					state_d = ppfb_pkg::BS_CLEAR;
				end
			end
			ppfb_pkg::BS_RMW:   state_d = ppfb_pkg::BS_IDLE;
			ppfb_pkg::BS_CLEAR: state_d = last ? ppfb_pkg::BS_IDLE : ppfb_pkg::BS_CLEAR;
			default:            state_d = ppfb_pkg::BS_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = cur_q.addr;
		wr_data  = merged;
		done_d   = 1'b0;
		result_d = '0;
		case (state_q)
			ppfb_pkg::BS_IDLE: begin
				pop   = !empty;
				rd_en = !empty && head_pixel;
				if (!empty && head_quick) begin
					done_d            = 1'b1;
					result_d.accepted = (head.op != ppfb_pkg::OP_REJECT);
				end
			end
			ppfb_pkg::BS_RMW: begin
				wr_en             = (cur_q.op == ppfb_pkg::OP_WRITE);
				done_d            = 1'b1;
				result_d.accepted = 1'b1;
				if (cur_q.op == ppfb_pkg::OP_READ) begin
					result_d.pixel_value = extracted;
				end
			end
			ppfb_pkg::BS_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_addr_q;
				wr_data = cur_q.data;
				if (last) begin
					done_d            = 1'b1;
					result_d.accepted = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ppfb_pkg::BS_IDLE;
			clr_addr_q <= '0;
			done_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == ppfb_pkg::BS_CLEAR) begin
				clr_addr_q <= last ? '0 : clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		result_q <= result_d;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[head.addr];
		end
	end

	assign active = (state_q != ppfb_pkg::BS_IDLE);
	assign done   = done_q;
	assign result = result_q;

	`PPFB_ASSERT_IMP(a_done_when_idle, clk, arst_n, done_q, state_q == ppfb_pkg::BS_IDLE)
	`PPFB_ASSERT_IMP(a_clr_addr_rest, clk, arst_n, state_q != ppfb_pkg::BS_CLEAR,
		clr_addr_q == '0)
	`PPFB_ASSERT_IMP(a_reject_zero, clk, arst_n, done_q && !result_q.accepted,
		result_q.pixel_value == 8'd0)
	`PPFB_ASSERT_NXT(a_rmw_done, clk, arst_n, state_q == ppfb_pkg::BS_RMW, done_q)

endmodule

/* src/packed_pixel_framebuffer.sv */
// ---------------------------------------------------------------------------
// packed_pixel_framebuffer
// Byte frame buffer of packed 1/2/4/8-bit pixels with pixel read, pixel
// read-modify-write and whole-frame clear.
// ---------------------------------------------------------------------------
//  channel  | handshake                         | payload
//  ---------+-----------------------------------+--------------------------
//  command  | start, busy (taken: start & !busy)| item   (item_t)
//  result   | done, one-cycle strobe            | result (result_t)
//  config   | APB psel/penable/pwrite, pready=1 | paddr, pwdata, prdata
//
// A pixel read or write goes from acceptance to the done strobe through the
// steps front classify, queue, memory read, then merge/write back; busy is
// low again in the cycle the strobe shows, and no new transaction is taken
// before then. A rejected or unknown transaction skips the memory read. A
// clear writes row_bytes * height bytes, one memory byte written each
// cycle through the single write port. Reset clears control state only;
// memory holds garbage until written or cleared. Results cannot be stalled.
// ---------------------------------------------------------------------------
module packed_pixel_framebuffer (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ppfb_pkg::item_t   item,
	output logic              done,
	output ppfb_pkg::result_t result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	ppfb_pkg::cfg_t cfg_q;
	ppfb_pkg::cmd_t fe_cmd, q_head;
	logic           take, push, pop, q_empty, q_full, fe_pending, be_active;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_width     <= 9'd256;
			cfg_q.frame_height    <= 9'd256;
			cfg_q.pixel_size_log2 <= 2'd0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				ppfb_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width     <= pwdata[8:0];
				ppfb_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height    <= pwdata[8:0];
				ppfb_pkg::REG_PIXEL_SIZE:   cfg_q.pixel_size_log2 <= pwdata[1:0];
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ppfb_pkg::REG_FRAME_WIDTH:  prdata = {23'd0, cfg_q.frame_width};
			ppfb_pkg::REG_FRAME_HEIGHT: prdata = {23'd0, cfg_q.frame_height};
			ppfb_pkg::REG_PIXEL_SIZE:   prdata = {30'd0, cfg_q.pixel_size_log2};
			default:                    prdata = 32'd0;
		endcase
	end

	assign busy = fe_pending || !q_empty || be_active;
	assign take = start && !busy;

	ppfb_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.take    (take),
		.item    (item),
		.cfg     (cfg_q),
		.full    (q_full),
		.push    (push),
		.cmd     (fe_cmd),
		.pending (fe_pending)
	);

	ppfb_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (fe_cmd),
		.pop    (pop),
		.head   (q_head),
		.empty  (q_empty),
		.full   (q_full)
	);

	ppfb_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (q_head),
		.empty  (q_empty),
		.pop    (pop),
		.active (be_active),
		.done   (done),
		.result (result)
	);

endmodule
